FILE: hdl/first_fit_block_allocator_defines.svh
// Assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define FFBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the next cycle
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hdl/ffba_pkg.sv
// Shared constants, types and status codes of the first-fit block allocator
package ffba_pkg;
	localparam int HeapBlocks = 4096;
	localparam int MaxSegments = 64;
	localparam int BlkW = 12;
	localparam int LenW = 13;
	localparam int SegAw = 6;
	localparam int CntW = 7;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_NO_SPACE = 3'd1;
	localparam status_t ST_NOT_ALLOC = 3'd2;
	localparam status_t ST_OVERLAP = 3'd3;
	localparam status_t ST_FULL = 3'd4;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	typedef struct packed {
		logic kind;
		logic [LenW-1:0] request_blocks;
		logic [BlkW-1:0] block_index;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [BlkW-1:0] start_block;
	} rsp_t;

	// one segment table entry: start and length
	typedef struct packed {
		logic [BlkW-1:0] start;
		logic [LenW-1:0] len;
	} seg_t;
endpackage

FILE: hdl/ffba_if.sv
// Valid/ready channel carrying request or response words
interface ffba_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [ffba_pkg::LenW-1:0] request_blocks;
	logic [ffba_pkg::BlkW-1:0] block_index;
	modport source(output valid, kind, request_blocks, block_index, input ready);
	modport sink(input valid, kind, request_blocks, block_index, output ready);
endinterface

interface ffba_rsp_if;
	logic valid;
	logic ready;
	ffba_pkg::status_t status;
	logic [ffba_pkg::BlkW-1:0] start_block;
	modport source(output valid, status, start_block, input ready);
	modport sink(input valid, status, start_block, output ready);
endinterface

FILE: hdl/ffba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module ffba_ram #(
	parameter int Aw = 6,
	parameter int Dw = 25
) (
	input  logic          clk,
	input  logic          we,
	input  logic [Aw-1:0] waddr,
	input  logic [Dw-1:0] wdata,
	input  logic [Aw-1:0] raddr,
	output logic [Dw-1:0] rdata
);
	logic [Dw-1:0] mem [2**Aw];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/ffba_core.sv
// Sequencer that scans, updates and shifts the segment table in RAM
module ffba_core (
	input  logic clk,
	input  logic arst_n,
	ffba_req_if.sink req,
	ffba_rsp_if.source rsp
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SZRD, S_SZCHK, S_SCAN, S_SCANW, S_PREVRD, S_PREVW,
		S_DECIDE, S_SHIFT, S_SHIFTW, S_WRITE, S_DONE
	} state_t;

	localparam int SzAw = $clog2(ffba_pkg::HeapBlocks);
	localparam int SegW = ffba_pkg::BlkW + ffba_pkg::LenW;

	state_t state_q;
	logic [SzAw-1:0] clr_q;
	logic [ffba_pkg::CntW-1:0] cnt_q;
	logic [ffba_pkg::CntW-1:0] pos_q;
	logic kind_q;
	logic [ffba_pkg::LenW-1:0] n_q;
	logic [ffba_pkg::BlkW-1:0] b_q;
	logic [ffba_pkg::LenW-1:0] size_q;
	ffba_pkg::seg_t prev_q;
	ffba_pkg::seg_t next_q;
	logic has_next_q;
	logic ins_q;
	logic out_valid_q;
	ffba_pkg::status_t st_q;
	logic [ffba_pkg::BlkW-1:0] sb_q;

	// segment RAM
	logic seg_we;
	logic [ffba_pkg::SegAw-1:0] seg_wa, seg_ra;
	ffba_pkg::seg_t seg_wd, seg_rd;
	ffba_ram #(.Aw(ffba_pkg::SegAw), .Dw(SegW)) u_seg (
		.clk(clk), .we(seg_we), .waddr(seg_wa), .wdata(seg_wd),
		.raddr(seg_ra), .rdata(seg_rd)
	);

	// size record memory, cleared after reset by a sweep
	logic sz_we;
	logic [SzAw-1:0] sz_wa;
	logic [ffba_pkg::LenW-1:0] sz_wd, sz_rd;
	ffba_ram #(.Aw(SzAw), .Dw(ffba_pkg::LenW)) u_size (
		.clk(clk), .we(sz_we), .waddr(sz_wa), .wdata(sz_wd),
		.raddr(b_q), .rdata(sz_rd)
	);

	logic [ffba_pkg::LenW:0] prev_end;
	logic [ffba_pkg::LenW:0] free_end;
	logic take_in;
	logic join_p, join_n;
	logic overlap, tbl_full, free_ok;

	assign take_in = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.status = st_q;
	assign rsp.start_block = sb_q;
	assign prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.len};
	assign free_end = {1'b0, b_q} + {1'b0, size_q};
	assign join_p = (pos_q != '0) && (prev_end == {1'b0, b_q});
	assign join_n = has_next_q && (free_end == {1'b0, next_q.start});
	assign overlap = (pos_q != '0 && prev_end > {1'b0, b_q})
		|| (has_next_q && free_end > {1'b0, next_q.start});
	assign tbl_full = cnt_q >= ffba_pkg::CntW'(ffba_pkg::MaxSegments);
	assign free_ok = !overlap && (join_p || join_n || !tbl_full);

	// drive memory ports from the sequencer
	always_comb begin
		seg_we = 1'b0;
		seg_wa = pos_q[ffba_pkg::SegAw-1:0];
		seg_wd = seg_rd;
		seg_ra = pos_q[ffba_pkg::SegAw-1:0];
		sz_we = 1'b0;
		sz_wa = b_q;
		sz_wd = '0;
		case (state_q)
			S_CLEAR: begin
				sz_we = 1'b1;
				sz_wa = clr_q;
				seg_we = (clr_q == '0);
				seg_wa = '0;
				seg_wd.start = '0;
				seg_wd.len = ffba_pkg::LenW'(ffba_pkg::HeapBlocks);
			end
			// record the size at the start of the granted region
			S_SCANW: begin
				sz_we = (kind_q == ffba_pkg::KIND_ALLOC) && (seg_rd.len >= n_q);
				sz_wa = seg_rd.start;
				sz_wd = n_q;
			end
			S_PREVRD: seg_ra = pos_q[ffba_pkg::SegAw-1:0] - 1'b1;
			// widen prev on a two-sided merge, clear the size record of a freed region
			S_DECIDE: begin
				seg_we = join_p && join_n;
				seg_wa = pos_q[ffba_pkg::SegAw-1:0] - 1'b1;
				seg_wd.start = prev_q.start;
				seg_wd.len = prev_q.len + size_q + next_q.len;
				sz_we = free_ok;
			end
			S_SHIFT: begin
				seg_ra = ins_q ? pos_q[ffba_pkg::SegAw-1:0] - 1'b1
					: pos_q[ffba_pkg::SegAw-1:0] + 1'b1;
			end
			S_SHIFTW: begin
				seg_we = 1'b1;
				seg_wd = seg_rd;
			end
			S_WRITE: begin
				seg_we = 1'b1;
				seg_wa = pos_q[ffba_pkg::SegAw-1:0];
				seg_wd = next_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= ffba_pkg::CntW'(1);
			pos_q <= '0;
			out_valid_q <= 1'b0;
			st_q <= ffba_pkg::ST_OK;
			sb_q <= '0;
			kind_q <= 1'b0;
			n_q <= '0;
			b_q <= '0;
			size_q <= '0;
			prev_q <= '0;
			next_q <= '0;
			has_next_q <= 1'b0;
			ins_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take_in) begin
						kind_q <= req.kind;
						n_q <= req.request_blocks;
						b_q <= req.block_index;
						pos_q <= '0;
						if (req.kind == ffba_pkg::KIND_FREE) begin
							state_q <= S_SZRD;
						end else if (req.request_blocks == '0) begin
							st_q <= ffba_pkg::ST_NO_SPACE;
							sb_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SZRD: state_q <= S_SZCHK;
				S_SZCHK: begin
					size_q <= sz_rd;
					if (sz_rd == '0) begin
						st_q <= ffba_pkg::ST_NOT_ALLOC;
						sb_q <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				// issue read of entry pos
				S_SCAN: begin
					if (pos_q >= cnt_q) begin
						if (kind_q == ffba_pkg::KIND_ALLOC) begin
							st_q <= ffba_pkg::ST_NO_SPACE;
							sb_q <= '0;
							state_q <= S_DONE;
						end else begin
							has_next_q <= 1'b0;
							state_q <= (pos_q != '0) ? S_PREVRD : S_DECIDE;
						end
					end else begin
						state_q <= S_SCANW;
					end
				end
				// examine entry pos
				S_SCANW: begin
					if (kind_q == ffba_pkg::KIND_ALLOC) begin
						if (seg_rd.len >= n_q) begin
							st_q <= ffba_pkg::ST_OK;
							sb_q <= seg_rd.start;
							size_q <= n_q;
							if (seg_rd.len == n_q) begin
								ins_q <= 1'b0;
								state_q <= S_SHIFT;
								cnt_q <= cnt_q - 1'b1;
								next_q.start <= seg_rd.start;
							end else begin
								next_q.start <= seg_rd.start + n_q[ffba_pkg::BlkW-1:0];
								next_q.len <= seg_rd.len - n_q;
								state_q <= S_WRITE;
							end
						end else begin
							pos_q <= pos_q + 1'b1;
							state_q <= S_SCAN;
						end
					end else if (seg_rd.start < b_q) begin
						pos_q <= pos_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						has_next_q <= 1'b1;
						next_q <= seg_rd;
						state_q <= (pos_q != '0) ? S_PREVRD : S_DECIDE;
					end
				end
				S_PREVRD: state_q <= S_PREVW;
				S_PREVW: begin
					prev_q <= seg_rd;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					sb_q <= '0;
					if (overlap) begin
						st_q <= ffba_pkg::ST_OVERLAP;
						state_q <= S_DONE;
					end else if (join_p && join_n) begin
						st_q <= ffba_pkg::ST_OK;
						// prev is widened this cycle, then remove entry pos
						ins_q <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
						state_q <= S_SHIFT;
					end else if (join_p) begin
						st_q <= ffba_pkg::ST_OK;
						pos_q <= pos_q - 1'b1;
						next_q.start <= prev_q.start;
						next_q.len <= prev_q.len + size_q;
						state_q <= S_WRITE;
					end else if (join_n) begin
						st_q <= ffba_pkg::ST_OK;
						next_q.start <= b_q;
						next_q.len <= next_q.len + size_q;
						state_q <= S_WRITE;
					end else if (tbl_full) begin
						st_q <= ffba_pkg::ST_FULL;
						state_q <= S_DONE;
					end else begin
						st_q <= ffba_pkg::ST_OK;
						next_q.start <= b_q;
						next_q.len <= size_q;
						ins_q <= 1'b1;
						// shift from the top down to pos
						has_next_q <= 1'b0;
						prev_q.start <= ffba_pkg::BlkW'(pos_q);
						pos_q <= cnt_q;
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_SHIFT;
					end
				end
				// read neighbor entry for the move
				S_SHIFT: begin
					if (ins_q) begin
						if (pos_q[ffba_pkg::CntW-1:0] == prev_q.start[ffba_pkg::CntW-1:0]) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_SHIFTW;
						end
					end else if (pos_q >= cnt_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFTW;
					end
				end
				S_SHIFTW: begin
					pos_q <= ins_q ? pos_q - 1'b1 : pos_q + 1'b1;
					state_q <= S_SHIFT;
				end
				// write the split, merged or inserted entry, then finish
				S_WRITE: state_q <= S_DONE;
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: hdl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator
//  channel | dir | fields
//  req     | in  | kind, request_blocks, block_index
//  rsp     | out | status, start_block
// Table entries are scanned and moved one at a time through the segment RAM, whose read data is registered.
// After reset a clearing pass sweeps all 4096 entries of the size memory; req.ready is low meanwhile.
// One item is in work at a time; rsp holds its word until taken.
module first_fit_block_allocator (
	input  logic clk,
	input  logic arst_n,
	ffba_req_if.sink req,
	ffba_rsp_if.source rsp
);
	// sequencer with segment and size memories
	ffba_core u_core (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
endmodule

FILE: hdl/ffba_checker.sv
// Port-level checker for the allocator, bound to the top level
`include "first_fit_block_allocator_defines.svh"
module ffba_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] rsp_status,
	input logic [11:0] rsp_start_block
);
	`FFBA_ASSERT_IMPL(a_start_zero, clk, arst_n, rsp_valid && rsp_status != ffba_pkg::ST_OK, rsp_start_block == '0)
	`FFBA_ASSERT_IMPL(a_status_range, clk, arst_n, rsp_valid, rsp_status <= ffba_pkg::ST_FULL)
	`FFBA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
	`FFBA_ASSERT_IMPL(a_no_accept_pending, clk, arst_n, rsp_valid, !req_ready)
	`FFBA_ASSERT_NEXT(a_one_in_work, clk, arst_n, req_valid && req_ready, !req_ready)
endmodule

bind first_fit_block_allocator ffba_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
	.rsp_start_block(rsp.start_block)
);

FILE: test/first_fit_block_allocator_tb.sv
// Testbench for the first-fit block allocator: scoreboard class, stimulus and checking
`timescale 1ns / 100ps

module first_fit_block_allocator_tb;
	typedef struct {
		ffba_pkg::status_t status;
		logic [ffba_pkg::BlkW-1:0] start_block;
	} outcome_t;

	// Heap mirror: free segment table plus size record per block
	class heap_scoreboard;
		int seg_start[$];
		int seg_len[$];
		int size_rec[ffba_pkg::HeapBlocks];
		outcome_t pending[$];
		int errors;
		int n_ok, n_nospace, n_notalloc, n_overlap, n_full;

		function new();
			seg_start = {0};
			seg_len = {ffba_pkg::HeapBlocks};
			foreach (size_rec[i]) size_rec[i] = 0;
			errors = 0;
		endfunction

		function outcome_t allocate(int n);
			outcome_t o;
			int s;
			o.status = ffba_pkg::ST_NO_SPACE;
			o.start_block = '0;
			if (n == 0) return o;
			foreach (seg_len[i]) begin
				if (seg_len[i] >= n) begin
					s = seg_start[i];
					if (seg_len[i] == n) begin
						seg_start.delete(i);
						seg_len.delete(i);
					end else begin
						seg_start[i] = s + n;
						seg_len[i] -= n;
					end
					size_rec[s] = n;
					o.status = ffba_pkg::ST_OK;
					o.start_block = ffba_pkg::BlkW'(s);
					return o;
				end
			end
			return o;
		endfunction

		function ffba_pkg::status_t release_region(int b);
			int sz, pos, stop;
			bit prev, next, jp, jn;
			if (b >= ffba_pkg::HeapBlocks) return ffba_pkg::ST_NOT_ALLOC;
			sz = size_rec[b];
			if (sz == 0) return ffba_pkg::ST_NOT_ALLOC;
			stop = b + sz;
			pos = 0;
			while (pos < seg_start.size() && seg_start[pos] < b) pos++;
			prev = pos > 0;
			next = pos < seg_start.size();
			if (prev && seg_start[pos-1] + seg_len[pos-1] > b) return ffba_pkg::ST_OVERLAP;
			if (next && stop > seg_start[pos]) return ffba_pkg::ST_OVERLAP;
			jp = prev && seg_start[pos-1] + seg_len[pos-1] == b;
			jn = next && stop == seg_start[pos];
			if (jp && jn) begin
				seg_len[pos-1] += sz + seg_len[pos];
				seg_start.delete(pos);
				seg_len.delete(pos);
			end else if (jp) begin
				seg_len[pos-1] += sz;
			end else if (jn) begin
				seg_start[pos] = b;
				seg_len[pos] += sz;
			end else begin
				if (seg_start.size() >= ffba_pkg::MaxSegments) return ffba_pkg::ST_FULL;
				seg_start.insert(pos, b);
				seg_len.insert(pos, sz);
			end
			size_rec[b] = 0;
			return ffba_pkg::ST_OK;
		endfunction

		// note an accepted request word and queue its outcome
		function void note_request(logic kind, int req_n, int idx);
			outcome_t o;
			if (kind == ffba_pkg::KIND_ALLOC) begin
				o = allocate(req_n);
			end else begin
				o.status = release_region(idx);
				o.start_block = '0;
			end
			case (o.status)
				ffba_pkg::ST_OK: n_ok++;
				ffba_pkg::ST_NO_SPACE: n_nospace++;
				ffba_pkg::ST_NOT_ALLOC: n_notalloc++;
				ffba_pkg::ST_OVERLAP: n_overlap++;
				default: n_full++;
			endcase
			pending.push_back(o);
		endfunction

		// compare a response word with the oldest outcome
		function void check_response(ffba_pkg::status_t st, logic [ffba_pkg::BlkW-1:0] blk);
			outcome_t o;
			if (pending.size() == 0) begin
				$error("response with nothing outstanding: status %0d", st);
				errors++;
				return;
			end
			o = pending.pop_front();
			if (st !== o.status) begin
				$error("status: expected %0d, got %0d", o.status, st);
				errors++;
			end
			if (blk !== o.start_block) begin
				$error("start_block: expected %0d, got %0d", o.start_block, blk);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	ffba_req_if req ();
	ffba_rsp_if rsp ();
	heap_scoreboard sb;
	int cycles;
	int live[$];

	localparam int CycleLimit = 3_000_000;

	first_fit_block_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// send one request word, hold until accepted
	task automatic send_word(logic kind, int req_n, int idx);
		req.valid <= 1'b1;
		req.kind <= kind;
		req.request_blocks <= req_n[ffba_pkg::LenW-1:0];
		req.block_index <= idx[ffba_pkg::BlkW-1:0];
		do @(posedge clk); while (!req.ready);
		sb.note_request(kind, req_n, idx);
		if (kind == ffba_pkg::KIND_ALLOC && sb.pending[$].status == ffba_pkg::ST_OK)
			live.push_back(sb.pending[$].start_block);
		if (kind == ffba_pkg::KIND_FREE && sb.pending[$].status == ffba_pkg::ST_OK)
			foreach (live[i]) if (live[i] == idx) begin
				live.delete(i);
				break;
			end
	endtask

	// drop valid for a random gap, or keep it in a burst
	task automatic maybe_gap(ref int burst);
		if (burst > 0) begin
			burst--;
			return;
		end
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
		burst = $urandom_range(0, 20);
	endtask

	task automatic alloc_word(int n);
		send_word(ffba_pkg::KIND_ALLOC, n, $urandom_range(0, 4095));
	endtask

	task automatic free_word(int b);
		send_word(ffba_pkg::KIND_FREE, $urandom_range(0, 8191), b);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// receiver: stall pattern is redrawn periodically from four modes
	initial begin
		int mode;
		rsp.ready = 1'b0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) sb.check_response(rsp.status, rsp.start_block);
			if (cycles % 400 == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 3) != 0);
				2: rsp.ready <= ((cycles % 7) < 2);
				default: rsp.ready <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int burst, n, k, r;
		sb = new();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = ffba_pkg::KIND_ALLOC;
		req.request_blocks = '0;
		req.block_index = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero request, errors, merges
		alloc_word(0);
		alloc_word(8191);
		alloc_word(4096);
		free_word(0);
		alloc_word(1);
		alloc_word(10);
		alloc_word(5);
		free_word(4095);
		free_word(3);
		free_word(1);
		free_word(1);
		free_word(0);
		free_word(11);
		alloc_word(16);
		alloc_word(4080);
		alloc_word(1);
		free_word(0);
		drain();

		// fill table with alternating holes until it is full
		for (int i = 0; i < 130; i++) alloc_word(2);
		alloc_word(4096 - 260);
		for (int i = 0; i < 130; i += 2) free_word(2 * i);
		free_word(2);
		drain();
		while (live.size() > 0) free_word(live.pop_front());
		free_word(0);
		drain();

		// random: mostly well-formed alloc/free of live regions
		burst = 0;
		for (int i = 0; i < 320; i++) begin
			maybe_gap(burst);
			k = $urandom_range(0, 99);
			if (k < 45) begin
				r = $urandom_range(0, 99);
				n = r < 80 ? $urandom_range(1, 64) :
				    r < 95 ? $urandom_range(65, 900) : $urandom_range(0, 8191);
				alloc_word(n);
			end else if (k < 85 && live.size() > 0) begin
				free_word(live[$urandom_range(0, live.size() - 1)]);
			end else begin
				free_word($urandom_range(0, 4095));
			end
			if (i == 160) drain();
		end
		drain();

		$display("covered: %0d ok, %0d no space, %0d not allocated, %0d overlap, %0d full",
			sb.n_ok, sb.n_nospace, sb.n_notalloc, sb.n_overlap, sb.n_full);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+hdl
hdl/ffba_pkg.sv
hdl/ffba_if.sv
hdl/ffba_ram.sv
hdl/ffba_core.sv
hdl/first_fit_block_allocator.sv
hdl/ffba_checker.sv
test/first_fit_block_allocator_tb.sv
